[rtl/core/sev_pkg.sv]
// ---------------------------------------------------------------------------
// sev_pkg - shared types and constants for sprite evaluation
// Item and result records, action codes, stepper phases and line timing.
// ---------------------------------------------------------------------------
package sev_pkg;

   // sizing
   localparam int SPRITES_TOTAL     = 64;
   localparam int SLOTS_PER_LINE    = 8;
   localparam int LAST_VISIBLE_LINE = 239;
   localparam int CURSOR_W          = $clog2(SPRITES_TOTAL);

   // dot timing within a line
   localparam int CLEAR_FIRST_DOT = 2;
   localparam int CLEAR_LAST_DOT  = 64;
   localparam int EVAL_FIRST_DOT  = 65;
   localparam int EVAL_LAST_DOT   = 256;

   // substep markers of the stepper
   localparam logic [2:0] SUB_Y_CHECK   = 3'd1;
   localparam logic [2:0] SUB_LAST_COPY = 3'd7;
   localparam logic [2:0] SUB_HIT_NEXT  = 3'd2;
   localparam logic [2:0] SUB_SCAN_DONE = 3'd5;

   localparam logic [7:0] FILL_BYTE      = 8'hFF;
   localparam logic [4:0] HEIGHT_DEFAULT = 5'd8;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_COPY,
      PH_OVER,
      PH_IDLE
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  mem_addr;
      logic [7:0]  mem_data;
      logic [8:0]  dot;
      logic        odd_dot;
      logic [8:0]  scanline;
   } item_type;

   typedef struct packed {
      logic [7:0]  oam_pointer;
      logic        overflow;
      logic [3:0]  found_count;
      logic        soam_we;
      logic [4:0]  soam_waddr;
      logic [7:0]  soam_wdata;
      logic [7:0]  read_byte;
      logic [5:0]  source_sprite;
   } result_type;

   typedef struct packed {
      logic        we;
      logic [7:0]  waddr;
      logic [7:0]  wdata;
      logic [7:0]  raddr;
   } ram_req_type;

   // primary address of byte m of sprite n
   function automatic logic [7:0] ptr_of(logic [CURSOR_W-1:0] n, logic [1:0] m);
      ptr_of = 8'({n, m});
   endfunction

endpackage

[rtl/core/sev_primary_ram.sv]
// ---------------------------------------------------------------------------
// sev_primary_ram - primary sprite memory
// 256 x 8, one write and one registered read per cycle, write-through on a
// same-address collision.
// ---------------------------------------------------------------------------
module sev_primary_ram (
   input  logic                 clock,
   input  sev_pkg::ram_req_type ram_req,
   output logic [7:0]           rdata
);

   logic [7:0] ram_ff [256];
   logic [7:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         ram_ff[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // read port, new data on collision
   always_ff @(posedge clock) begin
      if (ram_req.we && (ram_req.waddr == ram_req.raddr)) begin
         rdata_ff <= ram_req.wdata;
      end else begin
         rdata_ff <= ram_ff[ram_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/sev_eval_core.sv]
// ---------------------------------------------------------------------------
// sev_eval_core - evaluation stepper and secondary memory
// Processes one item per cycle from the input stage while item_go is high,
// holds stepper state, secondary memory and slot sources, and aims the
// primary read port at the item that is processed next.
// ---------------------------------------------------------------------------
module sev_eval_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [4:0]           csr_wdata,
   input  sev_pkg::item_type    item,
   input  logic                 item_go,
   input  logic [8:0]           next_dot,
   input  logic [7:0]           rd_data,
   output sev_pkg::result_type  result,
   output sev_pkg::ram_req_type ram_req
);

   localparam int CW = sev_pkg::CURSOR_W;

   // state registers
   logic [4:0]                height_ff;
   sev_pkg::phase_type        phase_ff, phase_in;
   logic [2:0]                sub_ff, sub_in;
   logic [3:0]                copied_ff, copied_in;
   logic [CW-1:0]             cursor_ff, cursor_in;
   logic [1:0]                byte_ff, byte_in;
   logic                      locked_ff, locked_in;
   logic [7:0]                latch_ff, latch_in;
   logic                      ovf_ff, ovf_in;
   logic [7:0]                ptr_ff, ptr_in;
   logic [7:0]                sec_mem_ff [32];
   logic [CW-1:0]             slot_src_ff [8];

   // state as seen by this item, after the start-of-evaluation restart
   sev_pkg::phase_type        e_phase;
   logic [2:0]                e_sub;
   logic [3:0]                e_copied;
   logic [CW-1:0]             e_cursor;
   logic [1:0]                e_byte;
   logic                      e_locked;
   logic [7:0]                e_latch;

   logic                      even;
   logic                      tick_ok, in_clear, in_eval, restart;
   logic                      copy_rd, copy_wr, over_rd;
   logic                      latch_hit, rd_hit;
   logic                      copy_miss, copy_full;
   logic [3:0]                copied_nx;
   logic [CW:0]               cursor_inc;
   logic                      wrap;
   logic [CW-1:0]             cursor_nx;
   logic [2:0]                sub_inc;

   logic                      soam_we;
   logic [4:0]                soam_waddr;
   logic [7:0]                soam_wdata;

   sev_pkg::phase_type        nx_phase;
   logic [2:0]                nx_sub;
   logic [CW-1:0]             nx_cursor;
   logic [1:0]                nx_byte;

   // Y range test: y <= line < y + height
   function automatic logic in_range(logic [8:0] line, logic [7:0] y, logic [4:0] h);
      in_range = (10'(line) >= 10'(y)) && (10'(line) < (10'(y) + 10'(h)));
   endfunction

   // item decode
   assign even     = !item.odd_dot;
   assign tick_ok  = (item.action == sev_pkg::ACT_TICK) &&
                     (item.scanline != 9'(sev_pkg::LAST_VISIBLE_LINE));
   assign in_clear = tick_ok && (item.dot <= 9'(sev_pkg::CLEAR_LAST_DOT));
   assign in_eval  = tick_ok && (item.dot > 9'(sev_pkg::CLEAR_LAST_DOT)) &&
                     (item.dot <= 9'(sev_pkg::EVAL_LAST_DOT));
   assign restart  = in_eval && (item.dot == 9'(sev_pkg::EVAL_FIRST_DOT));

   assign e_phase  = restart ? sev_pkg::PH_COPY : phase_ff;
   assign e_sub    = restart ? 3'd0 : sub_ff;
   assign e_copied = restart ? 4'd0 : copied_ff;
   assign e_cursor = restart ? '0 : cursor_ff;
   assign e_byte   = restart ? 2'd0 : byte_ff;
   assign e_locked = restart ? 1'b0 : locked_ff;
   assign e_latch  = restart ? 8'd0 : latch_ff;

   // stepper step decode
   assign copy_rd   = in_eval && (e_phase == sev_pkg::PH_COPY) && !e_sub[0] && even;
   assign copy_wr   = in_eval && (e_phase == sev_pkg::PH_COPY) && e_sub[0] && !even;
   assign over_rd   = in_eval && (e_phase == sev_pkg::PH_OVER) && even;
   assign latch_hit = in_range(item.scanline, e_latch, height_ff);
   assign rd_hit    = in_range(item.scanline, rd_data, height_ff);
   assign copy_miss = copy_wr && (e_sub == sev_pkg::SUB_Y_CHECK) && !latch_hit;
   assign copy_full = copy_wr && (e_sub == sev_pkg::SUB_LAST_COPY);
   assign copied_nx = e_copied + {3'd0, copy_full};
   assign cursor_inc = {1'b0, e_cursor} + (CW+1)'(1);
   assign wrap       = cursor_inc >= (CW+1)'(sev_pkg::SPRITES_TOTAL);
   assign cursor_nx  = wrap ? '0 : cursor_inc[CW-1:0];
   assign sub_inc    = e_sub + 3'd1;

   // next state
   always_comb begin
      phase_in  = e_phase;
      sub_in    = e_sub;
      copied_in = e_copied;
      cursor_in = e_cursor;
      byte_in   = e_byte;
      locked_in = e_locked;
      latch_in  = e_latch;
      ovf_in    = ovf_ff;
      ptr_in    = ptr_ff;

      if (item.action == sev_pkg::ACT_CLEAR) begin
         ovf_in = 1'b0;
      end

      if (copy_rd) begin
         ptr_in   = sev_pkg::ptr_of(e_cursor, e_sub[2:1]);
         latch_in = rd_data;
         sub_in   = sub_inc;
      end

      if (copy_wr) begin
         if (copy_miss || copy_full) begin
            // sprite done: move on to the next one
            copied_in = copied_nx;
            sub_in    = 3'd0;
            if (wrap) begin
               cursor_in = '0;
               phase_in  = sev_pkg::PH_IDLE;
            end else begin
               cursor_in = cursor_nx;
               if (copied_nx < 4'(sev_pkg::SLOTS_PER_LINE)) begin
                  phase_in = sev_pkg::PH_COPY;
               end else begin
                  if (copied_nx == 4'(sev_pkg::SLOTS_PER_LINE)) begin
                     locked_in = 1'b1;
                  end
                  phase_in = sev_pkg::PH_OVER;
               end
            end
         end else begin
            sub_in = sub_inc;
         end
      end

      if (over_rd) begin
         ptr_in   = sev_pkg::ptr_of(e_cursor, e_byte);
         latch_in = rd_data;
         byte_in  = e_byte + 2'd1;
         if (e_sub == 3'd0) begin
            if (rd_hit) begin
               ovf_in = 1'b1;
               sub_in = sev_pkg::SUB_HIT_NEXT;
               if (e_byte == 2'd3) begin
                  cursor_in = cursor_nx;
               end
            end else if (wrap) begin
               // diagonal scan: byte index moves without carry
               cursor_in = '0;
               phase_in  = sev_pkg::PH_IDLE;
            end else begin
               cursor_in = cursor_nx;
            end
         end else begin
            if (e_byte == 2'd3) begin
               cursor_in = cursor_nx;
            end
            sub_in = sub_inc;
            if (sub_inc >= sev_pkg::SUB_SCAN_DONE) begin
               phase_in = sev_pkg::PH_IDLE;
               sub_in   = 3'd0;
            end
         end
      end
   end

   // secondary write and result outputs
   always_comb begin
      soam_we    = 1'b0;
      soam_waddr = 5'd0;
      soam_wdata = 8'd0;
      if (in_clear && even && (item.dot >= 9'(sev_pkg::CLEAR_FIRST_DOT))) begin
         soam_we    = 1'b1;
         soam_waddr = item.dot[5:1] - 5'd1;
         soam_wdata = sev_pkg::FILL_BYTE;
      end else if (copy_wr && !e_locked) begin
         soam_we    = 1'b1;
         soam_waddr = {e_copied[2:0], e_sub[2:1]};
         soam_wdata = e_latch;
      end

      result.oam_pointer   = ptr_in;
      result.overflow      = ovf_in;
      result.found_count   = copied_in;
      result.soam_we       = soam_we;
      result.soam_waddr    = soam_waddr;
      result.soam_wdata    = soam_wdata;
      result.read_byte     = 8'd0;
      result.source_sprite = 6'd0;
      if (item.action == sev_pkg::ACT_READ) begin
         result.read_byte     = sec_mem_ff[item.mem_addr[4:0]];
         result.source_sprite = 6'(slot_src_ff[item.mem_addr[4:2]]);
      end
   end

   // read address for the item processed next cycle
   assign nx_phase  = item_go ? phase_in  : phase_ff;
   assign nx_sub    = item_go ? sub_in    : sub_ff;
   assign nx_cursor = item_go ? cursor_in : cursor_ff;
   assign nx_byte   = item_go ? byte_in   : byte_ff;

   always_comb begin
      ram_req.we    = item_go && (item.action == sev_pkg::ACT_WRITE);
      ram_req.waddr = item.mem_addr;
      ram_req.wdata = item.mem_data;
      if (next_dot == 9'(sev_pkg::EVAL_FIRST_DOT)) begin
         ram_req.raddr = 8'd0;
      end else if (nx_phase == sev_pkg::PH_COPY) begin
         ram_req.raddr = sev_pkg::ptr_of(nx_cursor, nx_sub[2:1]);
      end else begin
         ram_req.raddr = sev_pkg::ptr_of(nx_cursor, nx_byte);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= sev_pkg::HEIGHT_DEFAULT;
         phase_ff  <= sev_pkg::PH_COPY;
         sub_ff    <= 3'd0;
         copied_ff <= 4'd0;
         cursor_ff <= '0;
         byte_ff   <= 2'd0;
         locked_ff <= 1'b0;
         latch_ff  <= 8'd0;
         ovf_ff    <= 1'b0;
         ptr_ff    <= 8'd0;
      end else begin
         if (csr_we) begin
            height_ff <= csr_wdata;
         end
         if (item_go) begin
            phase_ff  <= phase_in;
            sub_ff    <= sub_in;
            copied_ff <= copied_in;
            cursor_ff <= cursor_in;
            byte_ff   <= byte_in;
            locked_ff <= locked_in;
            latch_ff  <= latch_in;
            ovf_ff    <= ovf_in;
            ptr_ff    <= ptr_in;
         end
      end
   end

   // secondary memory, all 0xFF after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            sec_mem_ff[i] <= sev_pkg::FILL_BYTE;
         end
      end else if (item_go && soam_we) begin
         sec_mem_ff[soam_waddr] <= soam_wdata;
      end
   end

   // slot sources
   always_ff @(posedge clock) begin
      if (item_go && copy_full) begin
         slot_src_ff[e_copied[2:0]] <= e_cursor;
      end
   end

endmodule

[rtl/core/sprite_evaluation_fsm.sv]
// ---------------------------------------------------------------------------
// sprite_evaluation_fsm - per-scanline sprite evaluation
// Primary memory writes, dot ticks, secondary reads and overflow clears,
// one result per item.
// ---------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| action, mem_addr, mem_data, dot, odd_dot, scanline
//   rsp     | out       | rsp_valid/rsp_stall| oam_pointer ... source_sprite
//   csr     | in        | csr_we             | csr_wdata (sprite height)
//
// One item per cycle, back to back, while rsp_stall is low; an item passes
// one input register and then one result register before rsp_valid rises.
// Primary memory is read ahead, at an address from the stepper's next state.
// Reset is synchronous; secondary memory comes up at 0xFF, primary memory
// is undefined until written.
// A stalled result holds the input stage, which then stalls req.
// ---------------------------------------------------------------------------
module sprite_evaluation_fsm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_mem_addr,
   input  logic [7:0]  req_mem_data,
   input  logic [8:0]  req_dot,
   input  logic        req_odd_dot,
   input  logic [8:0]  req_scanline,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_oam_pointer,
   output logic        rsp_overflow,
   output logic [3:0]  rsp_found_count,
   output logic        rsp_soam_we,
   output logic [4:0]  rsp_soam_waddr,
   output logic [7:0]  rsp_soam_wdata,
   output logic [7:0]  rsp_read_byte,
   output logic [5:0]  rsp_source_sprite,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   sev_pkg::item_type    in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   sev_pkg::result_type  out_res_ff;
   logic                 advance, load;
   logic [8:0]           next_dot;
   logic [7:0]           rd_data;
   sev_pkg::result_type  result;
   sev_pkg::ram_req_type ram_req;

   // handshake
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign load         = req_valid && !req_stall;
   assign in_valid_in  = load || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign next_dot     = load ? req_dot : in_item_ff.dot;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (load) begin
         in_item_ff.action   <= sev_pkg::action_type'(req_action);
         in_item_ff.mem_addr <= req_mem_addr;
         in_item_ff.mem_data <= req_mem_data;
         in_item_ff.dot      <= req_dot;
         in_item_ff.odd_dot  <= req_odd_dot;
         in_item_ff.scanline <= req_scanline;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= result;
      end
   end

   sev_primary_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rd_data)
   );

   sev_eval_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .item      (in_item_ff),
      .item_go   (advance),
      .next_dot  (next_dot),
      .rd_data   (rd_data),
      .result    (result),
      .ram_req   (ram_req)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_oam_pointer   = out_res_ff.oam_pointer;
   assign rsp_overflow      = out_res_ff.overflow;
   assign rsp_found_count   = out_res_ff.found_count;
   assign rsp_soam_we       = out_res_ff.soam_we;
   assign rsp_soam_waddr    = out_res_ff.soam_waddr;
   assign rsp_soam_wdata    = out_res_ff.soam_wdata;
   assign rsp_read_byte     = out_res_ff.read_byte;
   assign rsp_source_sprite = out_res_ff.source_sprite;

endmodule

[test/sprite_evaluation_fsm_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_evaluation_fsm_tb - self-checking bench for sprite evaluation
// Fills primary sprite memory and runs full and broken scanlines of dot
// ticks, mixed with memory writes, secondary reads, overflow clears and
// random noise items. Uses several sprite heights and random pacing on both
// channels. A scoreboard predicts every result and compares it field by field.
// ---------------------------------------------------------------------------

class eval_scoreboard;
   // evaluation state mirrored from the block
   logic [4:0]         height;
   logic [7:0]         pri_mem [256];
   logic [7:0]         sec_mem [32];
   sev_pkg::phase_type step_phase;
   logic [2:0]         substep;
   logic [3:0]         copied;
   logic [5:0]         spr_cur;
   logic [1:0]         byte_cur;
   logic               locked;
   logic [7:0]         latch;
   logic [5:0]         slot_src [8];
   logic               ovf;
   logic [7:0]         pointer;

   sev_pkg::result_type owed_q [$];
   int errors, checked, ovf_seen, soam_writes;

   function new();
      height = sev_pkg::HEIGHT_DEFAULT;
      foreach (pri_mem[i]) pri_mem[i] = '0;
      foreach (sec_mem[i]) sec_mem[i] = sev_pkg::FILL_BYTE;
      foreach (slot_src[i]) slot_src[i] = '0;
      restart_stepper();
      ovf = 1'b0;
      pointer = '0;
      errors = 0;
      checked = 0;
      ovf_seen = 0;
      soam_writes = 0;
   endfunction

   function void set_height(logic [4:0] v);
      height = v;
   endfunction

   function bit in_range(int line, logic [7:0] y);
      return line >= int'(y) && line < int'(y) + int'(height);
   endfunction

   function void restart_stepper();
      step_phase = sev_pkg::PH_COPY;
      substep = '0;
      copied = '0;
      spr_cur = '0;
      byte_cur = '0;
      locked = 1'b0;
      latch = '0;
   endfunction

   function void fetch(logic [5:0] n, logic [1:0] m);
      pointer = {n, m};
      latch = pri_mem[pointer];
   endfunction

   function void bump_sprite();
      spr_cur = (int'(spr_cur) == sev_pkg::SPRITES_TOTAL - 1) ? '0 : spr_cur + 1'b1;
   endfunction

   // byte index carries into the sprite index
   function void carry_byte();
      byte_cur = byte_cur + 1'b1;
      if (byte_cur == 2'd0) bump_sprite();
   endfunction

   // move on to the next sprite after a copy or a miss
   function void advance_sprite();
      substep = '0;
      if (int'(spr_cur) + 1 >= sev_pkg::SPRITES_TOTAL) begin
         spr_cur = '0;
         step_phase = sev_pkg::PH_IDLE;
      end else begin
         spr_cur = spr_cur + 1'b1;
         if (copied < sev_pkg::SLOTS_PER_LINE) begin
            step_phase = sev_pkg::PH_COPY;
         end else begin
            if (copied == sev_pkg::SLOTS_PER_LINE) locked = 1'b1;
            step_phase = sev_pkg::PH_OVER;
         end
      end
   endfunction

   // one evaluation dot: reads on even dots, copies on odd dots
   function void step_evaluation(bit even, int line, inout sev_pkg::result_type r);
      logic [2:0] s;
      logic [4:0] a;
      case (step_phase)
         sev_pkg::PH_COPY: begin
            s = substep;
            if (!s[0]) begin
               if (even) begin
                  fetch(spr_cur, s[2:1]);
                  substep = s + 1'b1;
               end
            end else if (!even) begin
               if (!locked) begin
                  a = {copied[2:0], s[2:1]};
                  sec_mem[a] = latch;
                  r.soam_we = 1'b1;
                  r.soam_waddr = a;
                  r.soam_wdata = latch;
               end
               if (s == sev_pkg::SUB_Y_CHECK && !in_range(line, latch)) begin
                  advance_sprite();
               end else if (s == sev_pkg::SUB_LAST_COPY) begin
                  slot_src[copied[2:0]] = spr_cur;
                  copied = copied + 1'b1;
                  advance_sprite();
               end else begin
                  substep = s + 1'b1;
               end
            end
         end
         sev_pkg::PH_OVER: begin
            if (even) begin
               fetch(spr_cur, byte_cur);
               if (substep == 3'd0) begin
                  if (in_range(line, latch)) begin
                     ovf = 1'b1;
                     carry_byte();
                     substep = sev_pkg::SUB_HIT_NEXT;
                  end else begin
                     // miss: byte index moves without carry
                     byte_cur = byte_cur + 1'b1;
                     if (int'(spr_cur) == sev_pkg::SPRITES_TOTAL - 1) begin
                        spr_cur = '0;
                        step_phase = sev_pkg::PH_IDLE;
                     end else begin
                        spr_cur = spr_cur + 1'b1;
                     end
                  end
               end else begin
                  carry_byte();
                  substep = substep + 1'b1;
                  if (substep >= sev_pkg::SUB_SCAN_DONE) begin
                     step_phase = sev_pkg::PH_IDLE;
                     substep = '0;
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   // accepted input transfer: predict its result
   function void note_item(sev_pkg::item_type it);
      sev_pkg::result_type r;
      logic [4:0]          a;
      r = '0;
      case (it.action)
         sev_pkg::ACT_WRITE: pri_mem[it.mem_addr] = it.mem_data;
         sev_pkg::ACT_READ: begin
            r.read_byte = sec_mem[it.mem_addr[4:0]];
            r.source_sprite = slot_src[it.mem_addr[4:2]];
         end
         sev_pkg::ACT_CLEAR: ovf = 1'b0;
         default: begin
            if (it.scanline != sev_pkg::LAST_VISIBLE_LINE) begin
               if (it.dot <= sev_pkg::CLEAR_LAST_DOT) begin
                  if (!it.odd_dot && it.dot >= sev_pkg::CLEAR_FIRST_DOT) begin
                     a = 5'(it.dot / 2 - 1);
                     sec_mem[a] = sev_pkg::FILL_BYTE;
                     r.soam_we = 1'b1;
                     r.soam_waddr = a;
                     r.soam_wdata = sev_pkg::FILL_BYTE;
                  end
               end else if (it.dot <= sev_pkg::EVAL_LAST_DOT) begin
                  if (it.dot == sev_pkg::EVAL_FIRST_DOT) restart_stepper();
                  step_evaluation(!it.odd_dot, int'(it.scanline), r);
               end
            end
         end
      endcase
      r.oam_pointer = pointer;
      r.overflow = ovf;
      r.found_count = copied;
      owed_q.push_back(r);
   endfunction

   function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // result transfer: compare against the oldest prediction
   function void check_result(sev_pkg::result_type got);
      sev_pkg::result_type want;
      if (owed_q.size() == 0) begin
         errors++;
         $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
         return;
      end
      want = owed_q.pop_front();
      checked++;
      if (want.overflow) ovf_seen++;
      if (want.soam_we) soam_writes++;
      cmp_field("oam_pointer", want.oam_pointer, got.oam_pointer);
      cmp_field("overflow", want.overflow, got.overflow);
      cmp_field("found_count", want.found_count, got.found_count);
      cmp_field("soam_we", want.soam_we, got.soam_we);
      cmp_field("soam_waddr", want.soam_waddr, got.soam_waddr);
      cmp_field("soam_wdata", want.soam_wdata, got.soam_wdata);
      cmp_field("read_byte", want.read_byte, got.read_byte);
      cmp_field("source_sprite", want.source_sprite, got.source_sprite);
   endfunction
endclass

module sprite_evaluation_fsm_tb;

   // random part size; setup and directed items come on top
   localparam int RANDOM_ITEMS = 1150;
   localparam int HOLD_CYCLES  = 80;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_action;
   logic [7:0] req_mem_addr;
   logic [7:0] req_mem_data;
   logic [8:0] req_dot;
   logic       req_odd_dot;
   logic [8:0] req_scanline;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_oam_pointer;
   logic       rsp_overflow;
   logic [3:0] rsp_found_count;
   logic       rsp_soam_we;
   logic [4:0] rsp_soam_waddr;
   logic [7:0] rsp_soam_wdata;
   logic [7:0] rsp_read_byte;
   logic [5:0] rsp_source_sprite;
   logic       csr_we;
   logic [4:0] csr_wdata;

   sev_pkg::result_type rsp_seen;
   eval_scoreboard      board;

   int items_sent;
   int burst_left;
   int lines_run;
   int noise_runs;
   int height_writes;
   int holds_done;

   sprite_evaluation_fsm u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_mem_addr      (req_mem_addr),
      .req_mem_data      (req_mem_data),
      .req_dot           (req_dot),
      .req_odd_dot       (req_odd_dot),
      .req_scanline      (req_scanline),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_oam_pointer   (rsp_oam_pointer),
      .rsp_overflow      (rsp_overflow),
      .rsp_found_count   (rsp_found_count),
      .rsp_soam_we       (rsp_soam_we),
      .rsp_soam_waddr    (rsp_soam_waddr),
      .rsp_soam_wdata    (rsp_soam_wdata),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_source_sprite (rsp_source_sprite),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   assign rsp_seen = {rsp_oam_pointer, rsp_overflow, rsp_found_count, rsp_soam_we,
                      rsp_soam_waddr, rsp_soam_wdata, rsp_read_byte, rsp_source_sprite};

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result check on every rsp transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_seen);
   end

   // receiver pacing: random modes, plus long hold-offs to back up the block
   initial begin : rsp_pacing
      int mode;
      int seg_left;
      mode = 0;
      seg_left = 0;
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < 2 && items_sent >= (holds_done + 1) * 700) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 80);
            mode = $urandom_range(0, 3);
         end
         seg_left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // offer one item, wait for its transfer, then maybe pause the sender
   task automatic push_item(input sev_pkg::action_type act, input logic [7:0] addr,
                            input logic [7:0] data, input logic [8:0] dot,
                            input logic odd, input logic [8:0] line);
      sev_pkg::item_type it;
      it.action = act;
      it.mem_addr = addr;
      it.mem_data = data;
      it.dot = dot;
      it.odd_dot = odd;
      it.scanline = line;
      req_valid <= 1'b1;
      req_action <= act;
      req_mem_addr <= addr;
      req_mem_data <= data;
      req_dot <= dot;
      req_odd_dot <= odd;
      req_scanline <= line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(it);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic park_sender();
      req_valid <= 1'b0;
   endtask

   // height change only once every result is back
   task automatic write_height(input logic [4:0] v);
      park_sender();
      while (board.owed_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_height(v);
      height_writes++;
   endtask

   function automatic logic [8:0] pick_line();
      if ($urandom_range(0, 11) == 0) return 9'(sev_pkg::LAST_VISIBLE_LINE);
      return 9'($urandom_range(0, 261));
   endfunction

   // random item of the given action, off any line
   task automatic push_random(input sev_pkg::action_type act);
      push_item(act, 8'($urandom), 8'($urandom), 9'($urandom_range(0, 340)),
                1'($urandom), pick_line());
   endtask

   // one scanline: seed Y bytes near the line, then tick through the dots
   task automatic run_line(input logic [8:0] line, input int y_writes,
                           input int stop_dot, input bit broken);
      int   off;
      int   y;
      int   r;
      logic odd;
      for (int k = 0; k < y_writes; k++) begin
         if ($urandom_range(0, 9) != 0) begin
            off = $urandom_range(0, int'(board.height) - 1);
            y = (int'(line) >= off) ? int'(line) - off : 0;
            if (y > 255) y = 255;
         end else begin
            y = $urandom_range(0, 255);
         end
         push_item(sev_pkg::ACT_WRITE, {6'($urandom_range(0, 63)), 2'b00}, 8'(y),
                   9'($urandom_range(0, 340)), 1'($urandom), pick_line());
      end
      repeat ($urandom_range(1, 4))
         push_random(sev_pkg::ACT_WRITE);
      for (int d = 1; d <= stop_dot; d++) begin
         if (broken && $urandom_range(0, 9) == 0) continue;
         r = $urandom_range(0, 99);
         if (r < 3)
            push_random(sev_pkg::ACT_READ);
         else if (r == 3)
            push_random(sev_pkg::ACT_WRITE);
         else if (r == 4)
            push_random(sev_pkg::ACT_CLEAR);
         odd = d[0];
         if (broken && $urandom_range(0, 19) == 0) odd = ~odd;
         push_item(sev_pkg::ACT_TICK, 8'($urandom), 8'($urandom), 9'(d), odd, line);
      end
      // read back part of secondary memory
      repeat (6)
         push_random(sev_pkg::ACT_READ);
      lines_run++;
   endtask

   // fully random items
   task automatic noise_burst(input int n);
      repeat (n)
         push_random(sev_pkg::action_type'($urandom_range(0, 3)));
      noise_runs++;
   endtask

   initial begin : stimulus
      int            base;
      int            guard;
      int            sel;
      int            stop_dot;
      int            y_counts [5];
      logic [4:0]    plan [5];
      board = new();
      y_counts = '{0, 4, 10, 20, 30};
      plan = '{5'd16, 5'd8, 5'd15, 5'd16, 5'd8};
      items_sent = 0;
      burst_left = 0;
      lines_run = 0;
      noise_runs = 0;
      height_writes = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= sev_pkg::ACT_WRITE;
      req_mem_addr <= '0;
      req_mem_data <= '0;
      req_dot <= '0;
      req_odd_dot <= 1'b0;
      req_scanline <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // setup: every primary byte written, all sprites cover line 100
      for (int a = 0; a < 256; a++)
         push_item(sev_pkg::ACT_WRITE, 8'(a), (a % 4 == 0) ? 8'd96 : 8'($urandom),
                   9'($urandom_range(0, 340)), 1'($urandom), pick_line());
      write_height(5'd8);
      // full line fills all eight slots and sets overflow
      for (int d = 1; d <= sev_pkg::EVAL_LAST_DOT; d++)
         push_item(sev_pkg::ACT_TICK, 8'($urandom), 8'($urandom), 9'(d), d[0], 9'd100);

      // directed: restart at dot 65 keeps the overflow flag
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd65, 1'b1, 9'd100);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd66, 1'b0, 9'd100);
      push_item(sev_pkg::ACT_CLEAR, 8'hFF, 8'hFF, 9'd0, 1'b0, 9'd0);
      push_item(sev_pkg::ACT_READ, 8'h00, 8'h00, 9'd0, 1'b0, 9'd0);
      push_item(sev_pkg::ACT_READ, 8'hFF, 8'hFF, 9'd340, 1'b1, 9'd261);
      push_item(sev_pkg::ACT_READ, 8'h1D, 8'h00, 9'd1, 1'b1, 9'd5);
      push_item(sev_pkg::ACT_WRITE, 8'h00, 8'h00, 9'd0, 1'b0, 9'd0);
      push_item(sev_pkg::ACT_WRITE, 8'hFF, 8'hFF, 9'd340, 1'b1, 9'd261);
      push_item(sev_pkg::ACT_WRITE, 8'h5A, 8'hA5, 9'd100, 1'b0, 9'd50);
      // clear dots: 0 and 1 clear nothing, 2..64 even dots fill
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd0, 1'b0, 9'd0);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd1, 1'b1, 9'd0);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd2, 1'b0, 9'd0);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd63, 1'b1, 9'd0);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd64, 1'b0, 9'd0);
      // last visible line ignores ticks
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd4, 1'b0,
                9'(sev_pkg::LAST_VISIBLE_LINE));
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd66, 1'b0,
                9'(sev_pkg::LAST_VISIBLE_LINE));
      // top of the evaluation window and dots past it
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd256, 1'b0, 9'd261);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd257, 1'b1, 9'd261);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd340, 1'b0, 9'd261);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd65, 1'b1, 9'd261);
      push_item(sev_pkg::ACT_TICK, 8'h00, 8'h00, 9'd66, 1'b0, 9'd261);
      push_item(sev_pkg::ACT_READ, 8'h04, 8'h00, 9'd0, 1'b0, 9'd0);

      // random part: mostly whole lines, some broken lines and noise
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (height_writes <= 5)
            write_height(plan[height_writes - 1]);
         else
            write_height(5'($urandom_range(8, 16)));
         if ($urandom_range(0, 6) == 0) begin
            noise_burst(40);
         end else begin
            sel = $urandom_range(0, 19);
            if (sel < 14) stop_dot = sev_pkg::EVAL_LAST_DOT;
            else if (sel < 17) stop_dot = $urandom_range(257, 340);
            else stop_dot = $urandom_range(66, 255);
            run_line(pick_line(), y_counts[$urandom_range(0, 4)], stop_dot,
                     $urandom_range(0, 5) == 0);
         end
      end

      // drain and settle
      park_sender();
      guard = 0;
      while (board.owed_q.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (board.owed_q.size() != 0) begin
         board.errors++;
         $display("%0t: %0d results never arrived", $time, board.owed_q.size());
      end
      $display("Covered %0d input transfers, %0d results checked, %0d lines, %0d noise bursts",
               items_sent, board.checked, lines_run, noise_runs);
      $display("Saw %0d secondary writes, %0d results with overflow, %0d height writes",
               board.soam_writes, board.ovf_seen, height_writes);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/sev_pkg.sv
rtl/core/sev_primary_ram.sv
rtl/core/sev_eval_core.sv
rtl/core/sprite_evaluation_fsm.sv
test/sprite_evaluation_fsm_tb.sv
